@@ rtl/core/sefr_pkg.sv @@
// Shared types, frame constants and the reply byte table for the STX/ETX receiver.
// No dependencies; every other file imports this package.
package sefr_pkg;

  localparam logic [7:0] BYTE_STX   = 8'h02;
  localparam logic [7:0] BYTE_ETX   = 8'h03;
  localparam logic [7:0] TYPE_CMD   = 8'h06;
  localparam logic [7:0] TYPE_DEBUG = 8'h00;
  localparam logic [8:0] HEADER_LEN = 9'd3;

  // Result index of the last transfer for each reply (index 0 is the message byte)
  localparam logic [3:0] ACK_LAST  = 4'd5;
  localparam logic [3:0] NACK_LAST = 4'd14;

  // ACK frame: 02 06 01 'A' 03
  localparam logic [7:0] ACK_FRAME [5] = '{8'h02, 8'h06, 8'h01, 8'h41, 8'h03};
  // Debug frame "error" followed by NACK frame 02 06 01 'N' 03
  localparam logic [7:0] NACK_FRAME [14] = '{
    8'h02, 8'h00, 8'h05, 8'h65, 8'h72, 8'h72, 8'h6F, 8'h72, 8'h03,
    8'h02, 8'h06, 8'h01, 8'h4E, 8'h03
  };

  typedef enum logic [1:0] {
    RESP_MSG  = 2'd0,  // plain message byte, one result
    RESP_ACK  = 2'd1,  // final byte, accepted
    RESP_NACK = 2'd2   // final byte, rejected
  } resp_e;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [7:0] msg_type;
    logic       frame_end;
    logic       frame_ok;
    logic       last;
  } res_item_t;

  // Work handed from the parser to the emitter
  typedef struct packed {
    resp_e      mode;
    logic [7:0] msg_byte;
    logic [7:0] msg_type;
  } job_t;

  // Transmit byte at result index idx (1-based within the reply)
  function automatic logic [7:0] tx_byte(resp_e mode, logic [3:0] idx);
    logic [3:0] k;
    logic [7:0] b;
    k = idx - 4'd1;
    b = 8'h00;
    case (mode)
      RESP_ACK:  b = (k < 4'd5) ? ACK_FRAME[k[2:0]] : 8'h00;
      RESP_NACK: b = (k < 4'd14) ? NACK_FRAME[k] : 8'h00;
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/core/sefr_if.sv @@
// Valid/ready channel interfaces for received bytes and for result items.
// Depends on sefr_pkg for the payload types.
interface sefr_rx_if;
  import sefr_pkg::*;
  logic     valid;
  logic     ready;
  rx_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sefr_res_if;
  import sefr_pkg::*;
  logic      valid;
  logic      ready;
  res_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/sefr_parser.sv @@
// Chunk parser: tracks header/message chunks and queues one reply job per message byte.
// Depends on sefr_pkg and sefr_rx_if.
module sefr_parser
  import sefr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sefr_rx_if.sink     rx,
  output logic        job_valid_o,
  output job_t        job_o,
  input  logic        job_ready_i
);

  logic [8:0] chunk_len_q, chunk_len_d;
  logic [8:0] pos_q, pos_d;
  logic       hdr_q, hdr_d;
  logic [7:0] type_q, type_d;
  logic       job_valid_q, job_valid_d;
  job_t       job_q, job_d;

  logic       accept;
  logic [7:0] b;
  logic [8:0] len;
  logic       final_byte;
  logic       hdr;
  logic [8:0] pos_inc;

  assign rx.ready = !job_valid_q || job_ready_i;
  assign accept   = rx.valid && rx.ready;
  assign b        = rx.payload.rx_byte;
  assign len      = (chunk_len_q == 9'd0) ? 9'd1 : chunk_len_q;
  assign pos_inc  = pos_q + 9'd1;
  assign final_byte = ({1'b0, pos_q} + 10'd1) >= {1'b0, len};
  assign hdr      = (pos_q == 9'd0) ? ((len == HEADER_LEN) && (b == BYTE_STX)) : hdr_q;

  always_comb begin
    chunk_len_d = chunk_len_q;
    pos_d       = pos_q;
    hdr_d       = hdr_q;
    type_d      = type_q;
    job_valid_d = job_valid_q && !job_ready_i;
    job_d       = job_q;
    if (accept) begin
      hdr_d = hdr;
      if (hdr) begin
        if (pos_q == 9'd1) begin
          type_d = b;
        end
        if (final_byte) begin
          chunk_len_d = {1'b0, b} + 9'd1;
          pos_d       = 9'd0;
        end else begin
          pos_d = pos_inc;
        end
      end else begin
        job_valid_d    = 1'b1;
        job_d.msg_byte = b;
        job_d.msg_type = type_q;
        if (!final_byte) begin
          job_d.mode = RESP_MSG;
          pos_d      = pos_inc;
        end else begin
          job_d.mode  = (b == BYTE_ETX) ? RESP_ACK : RESP_NACK;
          chunk_len_d = HEADER_LEN;
          pos_d       = 9'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_len_q <= HEADER_LEN;
      pos_q       <= 9'd0;
      hdr_q       <= 1'b0;
      type_q      <= 8'h00;
      job_valid_q <= 1'b0;
    end else begin
      chunk_len_q <= chunk_len_d;
      pos_q       <= pos_d;
      hdr_q       <= hdr_d;
      type_q      <= type_d;
      job_valid_q <= job_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

endmodule

@@ rtl/core/sefr_emitter.sv @@
// Reply emitter: plays out the message byte and any ACK/NACK frames, one transfer a cycle while res.ready is high.
// Depends on sefr_pkg and sefr_res_if.
module sefr_emitter
  import sefr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  input  job_t        job_i,
  output logic        job_ready_o,
  sefr_res_if.source  res
);

  logic       busy_q, busy_d;
  logic [3:0] idx_q, idx_d;
  job_t       job_q, job_d;

  logic       is_last;
  logic       out_xfer;
  logic       take;

  always_comb begin
    case (job_q.mode)
      RESP_ACK:  is_last = (idx_q == ACK_LAST);
      RESP_NACK: is_last = (idx_q == NACK_LAST);
      default:   is_last = 1'b1;
    endcase
  end

  assign out_xfer    = busy_q && res.ready;
  assign job_ready_o = !busy_q || (out_xfer && is_last);
  assign take        = job_valid_i && job_ready_o;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    job_d  = job_q;
    if (take) begin
      busy_d = 1'b1;
      idx_d  = 4'd0;
      job_d  = job_i;
    end else if (out_xfer) begin
      if (is_last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 4'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  always_comb begin
    res.valid = busy_q;
    res.payload.last = is_last;
    if (idx_q == 4'd0) begin
      res.payload.kind      = 1'b0;
      res.payload.data      = job_q.msg_byte;
      res.payload.msg_type  = job_q.msg_type;
      res.payload.frame_end = (job_q.mode != RESP_MSG);
      res.payload.frame_ok  = (job_q.mode == RESP_ACK);
    end else begin
      res.payload.kind      = 1'b1;
      res.payload.data      = tx_byte(job_q.mode, idx_q);
      res.payload.msg_type  = 8'h00;
      res.payload.frame_end = 1'b0;
      res.payload.frame_ok  = 1'b0;
    end
  end

endmodule

@@ rtl/core/stx_etx_frame_receiver_with_ack.sv @@
// STX/ETX frame receiver with ACK/NACK reply (top level).
// Depends on sefr_pkg, sefr_if, sefr_parser and sefr_emitter.
//
// Received bytes are grouped into chunks, 3 bytes after reset. A 3-byte chunk
// that opens with STX (0x02) is a header: its second byte is kept as the
// message type and its third byte plus one sets the next chunk length
// (1..256). Header bytes cause no transfer. Every other chunk is a message:
// each byte goes out as it arrives (kind 0, tagged with the stored type). On
// the final byte of a message the outcome is flagged: ending in ETX (0x03)
// means accepted and the ACK frame 02 06 01 'A' 03 follows; anything else
// means rejected and the debug frame 02 00 05 "error" 03 plus the NACK frame
// 02 06 01 'N' 03 follow (kind 1). The chunk length then returns to 3.
// Rate: the emitter gives one result transfer per cycle while the output is
// ready; a final byte's message result is followed by its reply frame. A
// one-job buffer between parser and emitter lets the next byte be taken
// while a result is stalled at the output.
module stx_etx_frame_receiver_with_ack
  import sefr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  sefr_rx_if.sink    rx_i,
  sefr_res_if.source res_o
);

  logic job_valid;
  logic job_ready;
  job_t job;

  // Chunk tracking and reply selection
  sefr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx          (rx_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_ready_i (job_ready)
  );

  // Sequenced output of message byte and reply frames
  sefr_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_ready_o (job_ready),
    .res         (res_o)
  );

endmodule
